// ----- design/axred_pkg.sv -----
// axred_pkg: shared constants, csr indexes and the front-to-back command type
// for the tensor axis reduction core; no dependencies
`default_nettype none

package axred_pkg;

   localparam int DATA_WIDTH_DEF  = 32;
   localparam int INNER_MAX_DEF   = 1024;
   localparam int INDEX_WIDTH_DEF = 16;

   localparam int ELEM_W      = 32;
   localparam int RIDX_W      = 16;
   localparam int POS_W       = 16;
   localparam int MODE_W      = 2;
   localparam int ICNT_W      = 11;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OP_MODE     = 2'd0,
      CSR_REDUCE_LEN  = 2'd1,
      CSR_INNER_COUNT = 2'd2
   } csr_index_type;

   localparam logic [MODE_W-1:0] MODE_SUM = 2'd0;

   typedef struct packed {
      logic              first;
      logic              last_red;
      logic              last_inner;
      logic [MODE_W-1:0] mode;
      logic [POS_W-1:0]  pos;
   } cmd_ctrl_type;

   localparam int CMD_CTRL_W = $bits(cmd_ctrl_type);

endpackage

`default_nettype wire

// ----- design/axred_ram.sv -----
// axred_ram: generic simple dual-port ram, one write and one registered read
// per cycle; no dependencies
`default_nettype none

module axred_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- design/axred_fifo.sv -----
// axred_fifo: small register-based queue with push/full and pop/empty sides
// no dependencies
`default_nettype none

module axred_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

// ----- design/axred_front.sv -----
// axred_front: csr registers, position counters and classification of each
// element into a command; depends on axred_pkg
`default_nettype none

module axred_front
   import axred_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int INNER_MAX  = INNER_MAX_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic [CSR_IDX_W-1:0]      csr_index,
   input  wire logic [CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                      req_push,
   input  wire logic signed [ELEM_W-1:0]  req_element_value,
   output logic                           req_full,
   output logic                           cmd_push,
   output cmd_ctrl_type                   cmd_ctrl,
   output logic [DATA_WIDTH-1:0]          cmd_value,
   output logic [(INNER_MAX > 1 ? $clog2(INNER_MAX) : 1)-1:0] cmd_slot,
   input  wire logic                      cmd_full
);

   localparam int SLOT_W = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
   localparam int LIM_W  = $clog2(INNER_MAX + 1);
   localparam int CMP_W  = ((LIM_W > ICNT_W) ? LIM_W : ICNT_W) + 1;

   logic [MODE_W-1:0] op_mode_ff, op_mode_in;
   logic [POS_W-1:0]  reduce_len_ff, reduce_len_in;
   logic [ICNT_W-1:0] inner_count_ff, inner_count_in;
   logic [POS_W-1:0]  reduce_pos_ff, reduce_pos_in;
   logic [SLOT_W-1:0] inner_pos_ff, inner_pos_in;

   logic [POS_W-1:0]  len;
   logic [CMP_W-1:0]  cnt_raw, cnt;
   logic              last_red, last_inner, accept;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;
   assign cmd_push = accept;

   assign len        = (reduce_len_ff == '0) ? POS_W'(1) : reduce_len_ff;
   assign last_red   = ({1'b0, reduce_pos_ff} + 1'b1) >= {1'b0, len};
   assign cnt_raw    = CMP_W'(inner_count_ff);
   assign cnt        = (cnt_raw == '0) ? CMP_W'(1)
                     : (cnt_raw > CMP_W'(INNER_MAX)) ? CMP_W'(INNER_MAX) : cnt_raw;
   assign last_inner = (CMP_W'(inner_pos_ff) + 1'b1) >= cnt;

   assign cmd_ctrl.first      = (reduce_pos_ff == '0);
   assign cmd_ctrl.last_red   = last_red;
   assign cmd_ctrl.last_inner = last_inner;
   assign cmd_ctrl.mode       = op_mode_ff;
   assign cmd_ctrl.pos        = reduce_pos_ff;
   assign cmd_value           = DATA_WIDTH'(req_element_value);
   assign cmd_slot            = inner_pos_ff;

   always_comb begin
      op_mode_in     = op_mode_ff;
      reduce_len_in  = reduce_len_ff;
      inner_count_in = inner_count_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_OP_MODE:     op_mode_in     = csr_wdata[MODE_W-1:0];
            CSR_REDUCE_LEN:  reduce_len_in  = csr_wdata[POS_W-1:0];
            CSR_INNER_COUNT: inner_count_in = csr_wdata[ICNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      reduce_pos_in = reduce_pos_ff;
      inner_pos_in  = inner_pos_ff;
      if (accept) begin
         if (last_inner) begin
            inner_pos_in  = '0;
            reduce_pos_in = last_red ? '0 : reduce_pos_ff + 1'b1;
         end else begin
            inner_pos_in = inner_pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_mode_ff     <= MODE_SUM;
         reduce_len_ff  <= POS_W'(1);
         inner_count_ff <= ICNT_W'(1);
         reduce_pos_ff  <= '0;
         inner_pos_ff   <= '0;
      end else begin
         op_mode_ff     <= op_mode_in;
         reduce_len_ff  <= reduce_len_in;
         inner_count_ff <= inner_count_in;
         reduce_pos_ff  <= reduce_pos_in;
         inner_pos_ff   <= inner_pos_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/axred_back.sv -----
// axred_back: per-slot read-modify-write on the accumulator ram with write
// forwarding, and the result queue; depends on axred_pkg, axred_ram, axred_fifo
`default_nettype none

module axred_back
   import axred_pkg::*;
#(
   parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
   parameter int INNER_MAX   = INNER_MAX_DEF,
   parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      cmd_empty,
   output logic                           cmd_pop,
   input  wire cmd_ctrl_type              cmd_ctrl,
   input  wire logic [DATA_WIDTH-1:0]     cmd_value,
   input  wire logic [(INNER_MAX > 1 ? $clog2(INNER_MAX) : 1)-1:0] cmd_slot,
   output logic                           rsp_empty,
   input  wire logic                      rsp_pop,
   output logic signed [ELEM_W-1:0]       rsp_result_value,
   output logic [RIDX_W-1:0]              rsp_result_index,
   output logic                           rsp_row_end
);

   localparam int SLOT_W = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
   localparam int RAM_W  = DATA_WIDTH + INDEX_WIDTH;
   localparam int OUT_W  = ELEM_W + RIDX_W + 1;
   localparam int CW     = $clog2(QUEUE_DEPTH + 1);

   cmd_ctrl_type            s1_ctrl_ff;
   logic                    s1_valid_ff;
   logic [DATA_WIDTH-1:0]   s1_value_ff;
   logic [SLOT_W-1:0]       s1_slot_ff;

   logic                    wr_valid_ff;
   logic [SLOT_W-1:0]       wr_slot_ff;
   logic [DATA_WIDTH-1:0]   wr_acc_ff;
   logic [INDEX_WIDTH-1:0]  wr_idx_ff;

   logic [CW-1:0]           out_used_ff, out_used_in;

   logic [RAM_W-1:0]        ram_rdata;
   logic [DATA_WIDTH-1:0]   old_acc, new_acc;
   logic [INDEX_WIDTH-1:0]  old_idx, new_idx;
   logic                    forward, out_push, out_full, rsp_take;
   logic [OUT_W-1:0]        out_wdata, out_rdata;

   assign cmd_pop = !cmd_empty && (!cmd_ctrl.last_red || out_used_ff < CW'(QUEUE_DEPTH));

   axred_ram #(
      .WIDTH (RAM_W),
      .DEPTH (INNER_MAX)
   ) u_store (
      .clock (clock),
      .we    (s1_valid_ff),
      .waddr (s1_slot_ff),
      .wdata ({new_acc, new_idx}),
      .raddr (cmd_slot),
      .rdata (ram_rdata)
   );

   // the write at the read edge is not seen by the ram read port
   assign forward = wr_valid_ff && (wr_slot_ff == s1_slot_ff);
   assign old_acc = forward ? wr_acc_ff : ram_rdata[RAM_W-1:INDEX_WIDTH];
   assign old_idx = forward ? wr_idx_ff : ram_rdata[INDEX_WIDTH-1:0];

   always_comb begin
      new_acc = old_acc;
      new_idx = old_idx;
      if (s1_ctrl_ff.first) begin
         new_acc = s1_value_ff;
         new_idx = '0;
      end else if (s1_ctrl_ff.mode == MODE_SUM) begin
         new_acc = old_acc + s1_value_ff;
      end else if ($signed(s1_value_ff) > $signed(old_acc)) begin
         new_acc = s1_value_ff;
         new_idx = INDEX_WIDTH'(s1_ctrl_ff.pos);
      end
   end

   assign out_push  = s1_valid_ff && s1_ctrl_ff.last_red;
   assign out_wdata = {ELEM_W'(new_acc),
                       (s1_ctrl_ff.mode == MODE_SUM) ? RIDX_W'(0) : RIDX_W'(new_idx),
                       s1_ctrl_ff.last_inner};

   axred_fifo #(
      .WIDTH (OUT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_wdata),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (out_rdata),
      .empty (rsp_empty)
   );

   assign rsp_result_value = out_rdata[OUT_W-1:RIDX_W+1];
   assign rsp_result_index = out_rdata[RIDX_W:1];
   assign rsp_row_end      = out_rdata[0];
   assign rsp_take         = rsp_pop && !rsp_empty;

   always_comb begin
      out_used_in = out_used_ff;
      if ((cmd_pop && cmd_ctrl.last_red) && !rsp_take) begin
         out_used_in = out_used_ff + 1'b1;
      end else if (!(cmd_pop && cmd_ctrl.last_red) && rsp_take) begin
         out_used_in = out_used_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wr_valid_ff <= 1'b0;
         out_used_ff <= '0;
      end else begin
         s1_valid_ff <= cmd_pop;
         wr_valid_ff <= s1_valid_ff;
         out_used_ff <= out_used_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ctrl_ff  <= cmd_ctrl;
      s1_value_ff <= cmd_value;
      s1_slot_ff  <= cmd_slot;
      wr_slot_ff  <= s1_slot_ff;
      wr_acc_ff   <= new_acc;
      wr_idx_ff   <= new_idx;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result queue overflow");

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      out_used_ff <= CW'(QUEUE_DEPTH))
      else $error("result credit out of range");

   a_issue_to_stage: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> s1_valid_ff)
      else $error("issued command lost");

   a_write_follows: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> wr_valid_ff && wr_slot_ff == $past(s1_slot_ff))
      else $error("forwarding record out of step");

endmodule

`default_nettype wire

// ----- design/tensor_axis_reduce_sum_max_argmax_core.sv -----
// Axis reduction core (sum, maximum, index of maximum) over a signed integer
// stream. Elements enter in memory order (outer, reduced, inner) and one beat
// is taken per clock unless the command queue is full. A front stage
// classifies each element by reduced and inner position, a four-entry command
// queue decouples it from the back stage, which does one read-modify-write of
// the per-inner-position store per cycle unless a result lacks queue space
// (registered ram read plus a one-deep write forward, so the same slot may be
// hit on consecutive beats). A result passes the command queue and back stage
// register. The store needs no clearing: every slot is overwritten at reduced
// position zero. Depends on axred_pkg, axred_front, axred_back, axred_fifo.
`default_nettype none

module tensor_axis_reduce_sum_max_argmax_core
   import axred_pkg::*;
#(
   parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
   parameter int INNER_MAX   = INNER_MAX_DEF,
   parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic [CSR_IDX_W-1:0]      csr_index,
   input  wire logic [CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                      push,
   input  wire logic signed [ELEM_W-1:0]  req_element_value,
   output logic                           full,
   output logic                           empty,
   input  wire logic                      pop,
   output logic signed [ELEM_W-1:0]       rsp_result_value,
   output logic [RIDX_W-1:0]              rsp_result_index,
   output logic                           rsp_row_end
);

   localparam int SLOT_W = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
   localparam int CMD_W  = CMD_CTRL_W + DATA_WIDTH + SLOT_W;

   cmd_ctrl_type          f_ctrl, b_ctrl;
   logic [DATA_WIDTH-1:0] f_value, b_value;
   logic [SLOT_W-1:0]     f_slot, b_slot;
   logic                  f_push, q_full, q_empty, b_pop;
   logic [CMD_W-1:0]      q_rdata;

   axred_front #(
      .DATA_WIDTH (DATA_WIDTH),
      .INNER_MAX  (INNER_MAX)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_push          (push),
      .req_element_value (req_element_value),
      .req_full          (full),
      .cmd_push          (f_push),
      .cmd_ctrl          (f_ctrl),
      .cmd_value         (f_value),
      .cmd_slot          (f_slot),
      .cmd_full          (q_full)
   );

   axred_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (f_push),
      .wdata ({f_ctrl, f_value, f_slot}),
      .full  (q_full),
      .pop   (b_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   assign b_ctrl  = q_rdata[CMD_W-1:DATA_WIDTH+SLOT_W];
   assign b_value = q_rdata[DATA_WIDTH+SLOT_W-1:SLOT_W];
   assign b_slot  = q_rdata[SLOT_W-1:0];

   axred_back #(
      .DATA_WIDTH  (DATA_WIDTH),
      .INNER_MAX   (INNER_MAX),
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_empty        (q_empty),
      .cmd_pop          (b_pop),
      .cmd_ctrl         (b_ctrl),
      .cmd_value        (b_value),
      .cmd_slot         (b_slot),
      .rsp_empty        (empty),
      .rsp_pop          (pop),
      .rsp_result_value (rsp_result_value),
      .rsp_result_index (rsp_result_index),
      .rsp_row_end      (rsp_row_end)
   );

endmodule

`default_nettype wire
